>>> design/tcw_pkg.sv
// ---------------------------------------------------------------------------
// tcw_pkg - shared definitions for the text console writer
// Screen geometry, field widths, character codes and the command that
// travels from the front end to the back end through the queue.
// ---------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CHAR_W = 8;
    localparam int CELL_W = 16;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // attributes are never rewritten, so every cell carries the reset attribute
    localparam logic [CHAR_W-1:0] ATTR_DEFAULT   = 8'h07;
    localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;
    localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h07;

    localparam logic ACTION_PUT  = 1'b0;
    localparam logic ACTION_READ = 1'b1;

    typedef struct packed {
        logic              do_write;
        logic              do_read;
        logic              do_clear;
        logic [ADDR_W-1:0] addr;
        logic [CHAR_W-1:0] chr;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
    } t_cmd;

    typedef struct packed {
        logic init_busy;
    } t_back_status;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ
    } t_back_state;

endpackage

>>> design/tcw_ram.sv
// ---------------------------------------------------------------------------
// tcw_ram - generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/tcw_front.sv
// ---------------------------------------------------------------------------
// tcw_front - item intake and cursor tracking
// Classify each item, advance the cursor and emit one command per item.
// ---------------------------------------------------------------------------
module tcw_front
    import tcw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_action,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [ROW_W-1:0]  i_read_row,
    input  logic [COL_W-1:0]  i_read_col,
    input  logic              i_q_full,
    input  t_back_status      i_status,
    output logic              o_push,
    output t_cmd              o_cmd
);

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] col_a;
    logic [ROW_W-1:0] row_a;
    logic             wrap_row;
    logic             accept;

    assign o_in_ready = !i_q_full && !i_status.init_busy;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept;

    always_comb begin
        o_cmd      = '0;
        col_a      = r_col;
        row_a      = r_row;
        wrap_row   = 1'b0;
        n_col      = r_col;
        n_row      = r_row;
        o_cmd.addr = ADDR_W'(r_row) * ADDR_W'(COLUMNS) + ADDR_W'(r_col);
        if (i_action == ACTION_READ) begin
            o_cmd.do_read = (i_read_row < ROW_W'(ROWS)) && (i_read_col < COL_W'(COLUMNS));
            o_cmd.addr    = ADDR_W'(i_read_row) * ADDR_W'(COLUMNS) + ADDR_W'(i_read_col);
        end else begin
            priority if (i_char_code == CODE_NEWLINE) begin
                col_a = '0;
                row_a = r_row + 1'b1;
            end else if (i_char_code == CODE_BACKSPACE) begin
                o_cmd.do_write = 1'b1;
                o_cmd.chr      = BLANK_CHAR;
                col_a          = (r_col != '0) ? r_col - 1'b1 : '0;
            end else begin
                o_cmd.do_write = 1'b1;
                o_cmd.chr      = i_char_code;
                col_a          = r_col + 1'b1;
            end
            // wrap at the right edge
            if (col_a >= COL_W'(COLUMNS)) begin
                col_a = '0;
                row_a = row_a + 1'b1;
            end
            wrap_row = (row_a >= ROW_W'(ROWS));
            if (wrap_row) begin
                col_a = '0;
                row_a = '0;
            end
            o_cmd.do_clear = wrap_row;
            n_col = col_a;
            n_row = row_a;
        end
        o_cmd.col = n_col;
        o_cmd.row = n_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

>>> design/tcw_queue.sv
// ---------------------------------------------------------------------------
// tcw_queue - short command queue
// Two-entry FIFO between the front end and the back end.
// ---------------------------------------------------------------------------
module tcw_queue
    import tcw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    t_cmd              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> design/tcw_back.sv
// ---------------------------------------------------------------------------
// tcw_back - screen store access and result register
// Carry out writes, reads and full-screen clears against the screen RAM.
// ---------------------------------------------------------------------------
module tcw_back
    import tcw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_q_empty,
    output logic              o_pop,
    output t_back_status      o_status,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CELL_W-1:0] o_cell_value,
    output logic [COL_W-1:0]  o_cursor_col_out,
    output logic [ROW_W-1:0]  o_cursor_row_out
);

    t_back_state       r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic              r_clr_after, n_clr_after;
    logic [COL_W-1:0]  r_sav_col, n_sav_col;
    logic [ROW_W-1:0]  r_sav_row, n_sav_row;

    logic              r_out_valid;
    logic [CELL_W-1:0] r_out_cell;
    logic [COL_W-1:0]  r_out_col;
    logic [ROW_W-1:0]  r_out_row;

    logic              out_free;
    logic              out_load;
    logic [CELL_W-1:0] out_cell;
    logic [COL_W-1:0]  out_col;
    logic [ROW_W-1:0]  out_row;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CHAR_W-1:0] ram_wdata;
    logic              ram_re;
    logic [CHAR_W-1:0] ram_rdata;

    // attribute byte is constant, so only the character byte is stored
    tcw_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CELL_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (i_cmd.addr),
        .o_rdata (ram_rdata)
    );

    assign out_free           = !r_out_valid || i_out_ready;
    assign o_status.init_busy = (r_state == ST_CLEAR) && !r_clr_after;

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_clr_after = r_clr_after;
        n_sav_col   = r_sav_col;
        n_sav_row   = r_sav_row;
        ram_we      = 1'b0;
        ram_waddr   = i_cmd.addr;
        ram_wdata   = i_cmd.chr;
        ram_re      = 1'b0;
        o_pop       = 1'b0;
        out_load    = 1'b0;
        out_cell    = '0;
        out_col     = i_cmd.col;
        out_row     = i_cmd.row;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = BLANK_CHAR;
                if (r_clr_addr == ADDR_W'(CELL_COUNT - 1)) begin
                    n_clr_addr  = '0;
                    n_clr_after = 1'b0;
                    n_state     = ST_IDLE;
                    out_load    = r_clr_after;
                    out_col     = r_sav_col;
                    out_row     = r_sav_row;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (!i_q_empty && out_free) begin
                    o_pop     = 1'b1;
                    ram_we    = i_cmd.do_write;
                    n_sav_col = i_cmd.col;
                    n_sav_row = i_cmd.row;
                    priority if (i_cmd.do_read) begin
                        ram_re  = 1'b1;
                        n_state = ST_READ;
                    end else if (i_cmd.do_clear) begin
                        n_clr_after = 1'b1;
                        n_state     = ST_CLEAR;
                    end else begin
                        out_load = 1'b1;
                    end
                end
            end
            ST_READ: begin
                out_load = 1'b1;
                out_cell = {ATTR_DEFAULT, ram_rdata};
                out_col  = r_sav_col;
                out_row  = r_sav_row;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_clr_after <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_clr_after <= n_clr_after;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sav_col <= n_sav_col;
        r_sav_row <= n_sav_row;
        if (out_load) begin
            r_out_cell <= out_cell;
            r_out_col  <= out_col;
            r_out_row  <= out_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_cell_value     = r_out_cell;
    assign o_cursor_col_out = r_out_col;
    assign o_cursor_row_out = r_out_row;

endmodule

>>> design/text_console_writer_top.sv
// ---------------------------------------------------------------------------
// text_console_writer_top - 80x25 character-cell text console
// Input channel: one transfer per item (put a character at the cursor, or
//   read one screen cell). Output channel: one transfer per item carrying the
//   read cell (zero on a put) and the cursor after the item.
// Path: a put's command passes the command queue, then the output register;
//   a read also passes the registered screen RAM read before the output register.
// Throughput: one put per cycle once the queue is primed and while the receiver
//   takes results; a read holds the back end in its read state, so the next
//   item waits. A put that scrolls past the last row blanks all 2000 cells,
//   one per cycle, before its result appears, and later items wait in the queue.
// Reset: cursor goes home and the screen store is swept to blanks, all 2000
//   cells, with input ready held low until the sweep is done.
// Receiver stall: the result is held in the output register; the back end
//   stops, the queue fills, then input ready drops.
// ---------------------------------------------------------------------------
module text_console_writer_top
    import tcw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_action,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [ROW_W-1:0]  i_read_row,
    input  logic [COL_W-1:0]  i_read_col,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CELL_W-1:0] o_cell_value,
    output logic [COL_W-1:0]  o_cursor_col_out,
    output logic [ROW_W-1:0]  o_cursor_row_out
);

    // front end -> queue
    logic         push;
    t_cmd         push_cmd;
    // queue -> back end
    t_cmd         head_cmd;
    logic         pop;
    logic         q_full;
    logic         q_empty;
    // back end status seen by the front end
    t_back_status status;

    // track the cursor and turn each transfer into a command
    tcw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_char_code (i_char_code),
        .i_read_row  (i_read_row),
        .i_read_col  (i_read_col),
        .i_q_full    (q_full),
        .i_status    (status),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    // decouple intake from screen access
    tcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // execute commands against the screen store and drive results
    tcw_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (head_cmd),
        .i_q_empty        (q_empty),
        .o_pop            (pop),
        .o_status         (status),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_cell_value     (o_cell_value),
        .o_cursor_col_out (o_cursor_col_out),
        .o_cursor_row_out (o_cursor_row_out)
    );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top - self-checking bench for the text console writer
// Drives put and read items into the console over the input channel and
// checks every result transfer against a shadow copy of the screen store and
// cursor kept here. A short scripted part covers reset contents, read range
// edges, control codes and extreme character values. Random bursts of text,
// newlines, backspaces and reads follow, so that lines wrap and the screen
// scrolls and clears many times. Both channels idle at random.
// ---------------------------------------------------------------------------
module tb_top;
    import tcw_pkg::*;

    localparam int RAND_ITEMS   = 1200;
    localparam int CALM_ITEMS   = 150;     // final stretch without idling
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_AT_ITEM = 400;     // where the receiver holds off long
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_AT     = 700;     // where the sender waits for a drain
    localparam int TAIL_CYCLES  = 20;
    localparam logic [CELL_W-1:0] ATTR_MASK  = 16'hFF00;
    localparam logic [CELL_W-1:0] CELL_BLANK = {ATTR_DEFAULT, BLANK_CHAR};

    // What one result transfer carries.
    typedef struct packed {
        logic [CELL_W-1:0] cell_val;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
    } t_console_view;

    // One scripted item; when typed is set the view below is the expectation.
    typedef struct {
        logic              act;
        logic [CHAR_W-1:0] code;
        logic [ROW_W-1:0]  rr;
        logic [COL_W-1:0]  rc;
        logic              typed;
        t_console_view     view;
    } t_script_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic              i_action;
    logic [CHAR_W-1:0] i_char_code;
    logic [ROW_W-1:0]  i_read_row;
    logic [COL_W-1:0]  i_read_col;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [CELL_W-1:0] o_cell_value;
    logic [COL_W-1:0]  o_cursor_col_out;
    logic [ROW_W-1:0]  o_cursor_row_out;

    // Shadow of the console: screen store and cursor.
    logic [CELL_W-1:0] shadow_screen [CELL_COUNT];
    logic [COL_W-1:0]  shadow_col;
    logic [ROW_W-1:0]  shadow_row;

    t_console_view views_due [$];
    t_script_row   script_rows [$];

    int  mismatch_count = 0;
    int  items_sent     = 0;
    int  rand_items     = 0;
    bit  calm_phase     = 1'b0;

    text_console_writer_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_char_code      (i_char_code),
        .i_read_row       (i_read_row),
        .i_read_col       (i_read_col),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_cell_value     (o_cell_value),
        .o_cursor_col_out (o_cursor_col_out),
        .o_cursor_row_out (o_cursor_row_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one item to the shadow console and return the view it produces.
    function automatic t_console_view console_apply(
        input logic              act,
        input logic [CHAR_W-1:0] code,
        input logic [ROW_W-1:0]  rr,
        input logic [COL_W-1:0]  rc
    );
        t_console_view v;
        int c;
        int r;
        int at;
        int i;
        v.cell_val = '0;
        c = int'(shadow_col);
        r = int'(shadow_row);
        if (act == ACTION_READ) begin
            // out-of-range reads return zero and touch nothing
            if (int'(rr) < ROWS && int'(rc) < COLUMNS)
                v.cell_val = shadow_screen[int'(rr) * COLUMNS + int'(rc)];
        end else begin
            at = r * COLUMNS + c;
            if (code == CODE_NEWLINE) begin
                c = 0;
                r = r + 1;
            end else if (code == CODE_BACKSPACE) begin
                // blank the cell under the cursor, step back but never below 0
                shadow_screen[at] = (shadow_screen[at] & ATTR_MASK) | BLANK_CHAR;
                if (c > 0)
                    c = c - 1;
            end else begin
                shadow_screen[at] = (shadow_screen[at] & ATTR_MASK) | code;
                c = c + 1;
            end
            if (c >= COLUMNS) begin
                c = 0;
                r = r + 1;
            end
            // scrolling past the last row blanks every character and homes
            if (r >= ROWS) begin
                for (i = 0; i < CELL_COUNT; i++)
                    shadow_screen[i] = (shadow_screen[i] & ATTR_MASK) | BLANK_CHAR;
                c = 0;
                r = 0;
            end
        end
        shadow_col = c[COL_W-1:0];
        shadow_row = r[ROW_W-1:0];
        v.col = shadow_col;
        v.row = shadow_row;
        return v;
    endfunction

    task automatic add_row(
        input logic              act,
        input logic [CHAR_W-1:0] code,
        input logic [ROW_W-1:0]  rr,
        input logic [COL_W-1:0]  rc,
        input logic              typed,
        input logic [CELL_W-1:0] cell_val,
        input logic [COL_W-1:0]  col,
        input logic [ROW_W-1:0]  row
    );
        t_script_row s;
        s.act           = act;
        s.code          = code;
        s.rr            = rr;
        s.rc            = rc;
        s.typed         = typed;
        s.view.cell_val = cell_val;
        s.view.col      = col;
        s.view.row      = row;
        script_rows.push_back(s);
    endtask

    // Offer one item, hold it until the transfer, then log its expectation.
    task automatic offer(
        input logic              act,
        input logic [CHAR_W-1:0] code,
        input logic [ROW_W-1:0]  rr,
        input logic [COL_W-1:0]  rc,
        input logic              typed,
        input t_console_view     typed_view
    );
        t_console_view predicted;
        int gap;
        i_in_valid  <= 1'b1;
        i_action    <= act;
        i_char_code <= code;
        i_read_row  <= rr;
        i_read_col  <= rc;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        // transfer taken at this edge
        predicted = console_apply(act, code, rr, rc);
        views_due.push_back(typed ? typed_view : predicted);
        items_sent++;
        if (!calm_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Result checker: compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_console_view want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (views_due.size() == 0) begin
                $display("%0t: unexpected result cell=%h col=%0d row=%0d", $time,
                         o_cell_value, o_cursor_col_out, o_cursor_row_out);
                mismatch_count++;
            end else begin
                want = views_due.pop_front();
                if (o_cell_value !== want.cell_val) begin
                    $display("%0t: cell_value expected %h actual %h", $time,
                             want.cell_val, o_cell_value);
                    mismatch_count++;
                end
                if (o_cursor_col_out !== want.col) begin
                    $display("%0t: cursor_col_out expected %0d actual %0d", $time,
                             want.col, o_cursor_col_out);
                    mismatch_count++;
                end
                if (o_cursor_row_out !== want.row) begin
                    $display("%0t: cursor_row_out expected %0d actual %0d", $time,
                             want.row, o_cursor_row_out);
                    mismatch_count++;
                end
            end
        end
    end

    // Receiver: random stall bursts, one long hold-off, none at the end.
    initial begin
        int  hold;
        bit  long_done;
        hold      = 0;
        long_done = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!long_done && items_sent >= HOLD_AT_ITEM) begin
                // hold off long enough for the queue to fill and input to stall
                long_done = 1'b1;
                hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                i_out_ready <= 1'b0;
                hold--;
            end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                hold = int'($urandom_range(1, 11)) - 1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if it hangs.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("%0t: timeout with %0d results outstanding", $time, views_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // Sender and run control.
    initial begin
        t_console_view none;
        int            i;
        int            kind;
        int            len;
        int            k;
        logic              act;
        logic [CHAR_W-1:0] code;
        logic [ROW_W-1:0]  rr;
        logic [COL_W-1:0]  rc;

        none        = '0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_action    = ACTION_PUT;
        i_char_code = '0;
        i_read_row  = '0;
        i_read_col  = '0;
        for (i = 0; i < CELL_COUNT; i++)
            shadow_screen[i] = CELL_BLANK;
        shadow_col = '0;
        shadow_row = '0;

        // reset contents and read range edges
        add_row(ACTION_READ, 8'h00,  5'd0,  7'd0,   1'b1, CELL_BLANK, 7'd0, 5'd0);
        add_row(ACTION_READ, 8'hFF,  5'd24, 7'd79,  1'b1, CELL_BLANK, 7'd0, 5'd0);
        add_row(ACTION_READ, 8'h00,  5'd25, 7'd0,   1'b1, 16'h0000,   7'd0, 5'd0);
        add_row(ACTION_READ, 8'h00,  5'd0,  7'd80,  1'b1, 16'h0000,   7'd0, 5'd0);
        add_row(ACTION_READ, 8'hFF,  5'd31, 7'd127, 1'b1, 16'h0000,   7'd0, 5'd0);
        // backspace at column 0 holds the column
        add_row(ACTION_PUT,  CODE_BACKSPACE, 5'd31, 7'd127, 1'b1, 16'h0000, 7'd0, 5'd0);
        // character extremes, zero printed as an ordinary character
        add_row(ACTION_PUT,  8'h41,  5'd0,  7'd0,   1'b1, 16'h0000,   7'd1, 5'd0);
        add_row(ACTION_PUT,  8'h00,  5'd0,  7'd0,   1'b1, 16'h0000,   7'd2, 5'd0);
        add_row(ACTION_PUT,  8'hFF,  5'd0,  7'd0,   1'b1, 16'h0000,   7'd3, 5'd0);
        add_row(ACTION_READ, 8'h00,  5'd0,  7'd0,   1'b1, 16'h0741,   7'd3, 5'd0);
        add_row(ACTION_READ, 8'h00,  5'd0,  7'd1,   1'b1, 16'h0700,   7'd3, 5'd0);
        add_row(ACTION_READ, 8'h00,  5'd0,  7'd2,   1'b1, 16'h07FF,   7'd3, 5'd0);
        // backspace blanks the cell under the cursor, then steps back
        add_row(ACTION_PUT,  CODE_BACKSPACE, 5'd0, 7'd0, 1'b1, 16'h0000, 7'd2, 5'd0);
        add_row(ACTION_PUT,  CODE_BACKSPACE, 5'd0, 7'd0, 1'b1, 16'h0000, 7'd1, 5'd0);
        add_row(ACTION_READ, 8'h00,  5'd0,  7'd2,   1'b1, CELL_BLANK, 7'd1, 5'd0);
        // newline goes to column 0 of the next row
        add_row(ACTION_PUT,  CODE_NEWLINE, 5'd0, 7'd0, 1'b1, 16'h0000, 7'd0, 5'd1);
        add_row(ACTION_PUT,  8'h55,  5'd0,  7'd0,   1'b0, 16'h0000,   7'd0, 5'd0);
        add_row(ACTION_READ, 8'h00,  5'd1,  7'd0,   1'b0, 16'h0000,   7'd0, 5'd0);
        add_row(ACTION_PUT,  CODE_NEWLINE, 5'd0, 7'd0, 1'b0, 16'h0000, 7'd0, 5'd0);
        add_row(ACTION_PUT,  CODE_NEWLINE, 5'd0, 7'd0, 1'b0, 16'h0000, 7'd0, 5'd0);
        add_row(ACTION_PUT,  8'h80,  5'd0,  7'd0,   1'b0, 16'h0000,   7'd0, 5'd0);
        add_row(ACTION_READ, 8'h00,  5'd3,  7'd0,   1'b0, 16'h0000,   7'd0, 5'd0);
        add_row(ACTION_READ, 8'h00,  5'd16, 7'd64,  1'b0, 16'h0000,   7'd0, 5'd0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script_rows[j])
            offer(script_rows[j].act, script_rows[j].code, script_rows[j].rr,
                  script_rows[j].rc, script_rows[j].typed, script_rows[j].view);

        // Random bursts: text runs long enough to wrap lines, newline runs that
        // scroll the screen to a clear, backspace runs that hit column 0, reads.
        while (rand_items < RAND_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 35)
                len = $urandom_range(10, 90);
            else if (kind < 65)
                len = $urandom_range(1, 16);
            else if (kind < 80)
                len = $urandom_range(1, 12);
            else
                len = $urandom_range(1, 10);
            for (k = 0; k < len && rand_items < RAND_ITEMS; k++) begin
                if (rand_items == DRAIN_AT) begin
                    // pause until every outstanding result has come back
                    i_in_valid <= 1'b0;
                    while (views_due.size() != 0)
                        @(posedge i_clk);
                end
                if (rand_items >= RAND_ITEMS - CALM_ITEMS)
                    calm_phase = 1'b1;
                act  = ACTION_PUT;
                code = CHAR_W'($urandom_range(0, 255));
                rr   = ROW_W'($urandom_range(0, 31));
                rc   = COL_W'($urandom_range(0, 127));
                if (kind < 35) begin
                    // text, with an occasional read near the cursor
                    if ($urandom_range(0, 9) == 0) begin
                        act = ACTION_READ;
                        rr  = shadow_row;
                        rc  = (shadow_col > 0) ? shadow_col - 1'b1 : shadow_col;
                    end
                end else if (kind < 65) begin
                    code = CODE_NEWLINE;
                end else if (kind < 80) begin
                    code = CODE_BACKSPACE;
                end else begin
                    act = ACTION_READ;
                    case ($urandom_range(0, 6))
                        0: begin
                            rr = ROW_W'($urandom_range(ROWS, 31));
                        end
                        1: begin
                            rc = COL_W'($urandom_range(COLUMNS, 127));
                        end
                        2: begin
                            rr = shadow_row;
                            rc = shadow_col;
                        end
                        default: begin
                            rr = ROW_W'($urandom_range(0, ROWS - 1));
                            rc = COL_W'($urandom_range(0, COLUMNS - 1));
                        end
                    endcase
                end
                offer(act, code, rr, rc, 1'b0, none);
                rand_items++;
            end
        end

        // Drop valid, drain the outstanding results, then idle for TAIL_CYCLES.
        i_in_valid <= 1'b0;
        while (views_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && views_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
